[rtl/euler_to_quaternion_top_defines.svh]
// Assertion macros for the Euler-to-quaternion block.
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// Same-cycle implication, checked in reset too.
`define EQC_ASSERT_NOW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define EQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/eqc_pkg.sv]
// Shared types and constants for the Euler-to-quaternion block.
package eqc_pkg;

   localparam int ZW        = 48;  // angle, 1e-11 degree units
   localparam int XW        = 36;  // CORDIC x/y, 32 fraction bits
   localparam int SCW       = 33;  // sine/cosine, 30 fraction bits
   localparam int PW        = 2 * SCW;
   localparam int ATAN_LEN  = 24;
   localparam int REM_STEPS = 7;

   localparam logic [31:0]           FULL_TURN = 32'd23592960;   // 360 in Q16.16
   localparam logic [25:0]           DEG_SCALE = 26'd48828125;   // 10^11 / 2^11
   localparam logic signed [ZW-1:0]  DEG90     = 48'sd9000000000000;
   localparam logic signed [ZW-1:0]  DEG180    = 48'sd18000000000000;
   localparam logic signed [XW-1:0]  GAIN      = 36'sd2608131496;

   localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_LEN] = '{
      48'sd4500000000000, 48'sd2656505117708, 48'sd1403624346793, 48'sd712501634890,
      48'sd357633437500, 48'sd178991060825, 48'sd89517371021, 48'sd44761417086,
      48'sd22381050037, 48'sd11190567707, 48'sd5595289189, 48'sd2797645262,
      48'sd1398822714, 48'sd699411368, 48'sd349705685, 48'sd174852843,
      48'sd87426421, 48'sd43713211, 48'sd21856605, 48'sd10928303,
      48'sd5464151, 48'sd2732076, 48'sd1366038, 48'sd683019
   };

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } rem_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } rot_type;

   typedef struct packed {
      logic signed [SCW-1:0] s;
      logic signed [SCW-1:0] c;
   } sc_type;

endpackage

[rtl/eqc_rem_cell.sv]
// One restoring step of the modulo-360 reduction.
module eqc_rem_cell #(
   parameter int K = 0
) (
   input  logic             clock,
   input  logic             en,
   input  eqc_pkg::rem_type d,
   output eqc_pkg::rem_type q
);
   localparam logic [31:0] STEP = 32'(64'(eqc_pkg::FULL_TURN) << K);

   eqc_pkg::rem_type q_ff, q_in;

   always_comb begin
      q_in = d;
      if (d.mag >= STEP) begin
         q_in.mag = d.mag - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

[rtl/eqc_cordic_cell.sv]
// One rotation step of the CORDIC chain.
module eqc_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             en,
   input  eqc_pkg::rot_type d,
   output eqc_pkg::rot_type q
);
   eqc_pkg::rot_type q_ff, q_in;

   always_comb begin
      q_in = d;
      if (!d.z[eqc_pkg::ZW-1]) begin
         q_in.x = d.x - (d.y >>> IDX);
         q_in.y = d.y + (d.x >>> IDX);
         q_in.z = d.z - eqc_pkg::ATAN_TABLE[IDX];
      end else begin
         q_in.x = d.x + (d.y >>> IDX);
         q_in.y = d.y - (d.x >>> IDX);
         q_in.z = d.z + eqc_pkg::ATAN_TABLE[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

[rtl/eqc_angle.sv]
// Sine and cosine of half an angle: reduction, scaling, folding, CORDIC chain.
module eqc_angle #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] angle,
   output eqc_pkg::sc_type    sc
);
   localparam int NST = (CORDIC_STAGES > eqc_pkg::ATAN_LEN) ?
                        eqc_pkg::ATAN_LEN : CORDIC_STAGES;

   eqc_pkg::rem_type rem_chain [eqc_pkg::REM_STEPS+1];
   eqc_pkg::rot_type rot_chain [NST+1];

   logic [50:0]                  prod;
   logic [44:0]                  hmag;
   logic signed [eqc_pkg::ZW-1:0] z_in, z_ff;
   eqc_pkg::rot_type             rot_in, rot_ff;
   logic signed [eqc_pkg::XW-1:0] xr, yr;
   eqc_pkg::sc_type              sc_in, sc_ff;

   assign rem_chain[0].neg = angle[31];
   assign rem_chain[0].mag = angle[31] ? (~angle + 32'd1) : angle;

   for (genvar k = 0; k < eqc_pkg::REM_STEPS; k++) begin : g_rem
      eqc_rem_cell #(.K(eqc_pkg::REM_STEPS - 1 - k)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (rem_chain[k]),
         .q     (rem_chain[k+1])
      );
   end

   // |rem| * 10^11 / 2^17, rounded half away
   always_comb begin
      prod = 51'(rem_chain[eqc_pkg::REM_STEPS].mag[24:0]) * 51'(eqc_pkg::DEG_SCALE);
      hmag = 45'((prod + 51'd32) >> 6);
      z_in = rem_chain[eqc_pkg::REM_STEPS].neg ? -$signed({3'b000, hmag})
                                               : $signed({3'b000, hmag});
   end

   // quadrant fold
   always_comb begin
      rot_in.x    = eqc_pkg::GAIN;
      rot_in.y    = '0;
      rot_in.z    = z_ff;
      rot_in.flip = 1'b0;
      if (z_ff > eqc_pkg::DEG90) begin
         rot_in.z    = z_ff - eqc_pkg::DEG180;
         rot_in.flip = 1'b1;
      end else if (z_ff < -eqc_pkg::DEG90) begin
         rot_in.z    = z_ff + eqc_pkg::DEG180;
         rot_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff   <= z_in;
         rot_ff <= rot_in;
         sc_ff  <= sc_in;
      end
   end

   assign rot_chain[0] = rot_ff;

   for (genvar i = 0; i < NST; i++) begin : g_cordic
      eqc_cordic_cell #(.IDX(i)) u_cell (
         .clock (clock),
         .en    (en),
         .d     (rot_chain[i]),
         .q     (rot_chain[i+1])
      );
   end

   always_comb begin
      xr = (rot_chain[NST].x + 36'sd2) >>> 2;
      yr = (rot_chain[NST].y + 36'sd2) >>> 2;
      sc_in.c = rot_chain[NST].flip ? -xr[eqc_pkg::SCW-1:0] : xr[eqc_pkg::SCW-1:0];
      sc_in.s = rot_chain[NST].flip ? -yr[eqc_pkg::SCW-1:0] : yr[eqc_pkg::SCW-1:0];
   end

   assign sc = sc_ff;
endmodule

[rtl/euler_to_quaternion_top.sv]
// Euler angles (Q16.16 degrees) to a unit quaternion (signed Q1.15), fully pipelined.
// Throughput: one item per cycle unless a held result stalls the pipe;
// each CORDIC cell and product stage is its own register.
// The whole pipe advances together; a held result stalls it and drops req_ready.
// Reset (synchronous, active high) clears only the valid bits; no payload is reset.
module euler_to_quaternion_top #(
   parameter int CORDIC_STAGES = 16,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [31:0]         req_pitch_deg,
   input  logic signed [31:0]         req_yaw_deg,
   input  logic signed [31:0]         req_roll_deg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_FRAC_BITS:0] rsp_quat_x,
   output logic signed [OUT_FRAC_BITS:0] rsp_quat_y,
   output logic signed [OUT_FRAC_BITS:0] rsp_quat_z,
   output logic signed [OUT_FRAC_BITS:0] rsp_quat_w
);
`include "euler_to_quaternion_top_defines.svh"

   localparam int NST = (CORDIC_STAGES > eqc_pkg::ATAN_LEN) ?
                        eqc_pkg::ATAN_LEN : CORDIC_STAGES;
   localparam int QW  = OUT_FRAC_BITS + 1;
   localparam int SW  = eqc_pkg::PW + 2;      // sum of two 60-fraction products
   localparam int SH  = 60 - OUT_FRAC_BITS;
   // angle unit NST+10, product/round/product/sum 4
   localparam int LAT = NST + 14;
   localparam logic signed [SW-1:0] HALF60 = SW'(1) <<< 29;
   localparam logic signed [SW-1:0] RHALF  = SW'(1) <<< (SH - 1);
   localparam logic signed [SW-1:0] QHI    = (SW'(1) <<< OUT_FRAC_BITS) - SW'(1);
   localparam logic signed [SW-1:0] QLO    = -(SW'(1) <<< OUT_FRAC_BITS);

   // Advance whenever the output register is free or being drained.
   logic adv;
   logic [LAT-1:0] valid_ff, valid_in;
   logic           rsp_valid_ff;

   eqc_pkg::sc_type pit, yaw, rol;
   eqc_pkg::sc_type yaw1_ff, yaw2_ff;

   // two-factor products, then rounded to 30 fraction bits
   logic signed [eqc_pkg::PW-1:0]  m_crsp_ff, m_srcp_ff, m_crcp_ff, m_srsp_ff;
   logic signed [eqc_pkg::SCW-1:0] r_crsp_ff, r_srcp_ff, r_crcp_ff, r_srsp_ff;
   // three-factor terms
   logic signed [eqc_pkg::PW-1:0]  t_ff [8];
   logic signed [SW-1:0]           qx_ff, qy_ff, qz_ff, qw_ff;
   logic [QW-1:0] ox_ff, oy_ff, oz_ff, ow_ff;

   function automatic logic signed [eqc_pkg::SCW-1:0] rnd30(
      input logic signed [eqc_pkg::PW-1:0] v
   );
      logic signed [SW-1:0] r;
      r = (SW'(v) + HALF60) >>> 30;
      return r[eqc_pkg::SCW-1:0];
   endfunction

   function automatic logic [QW-1:0] to_out(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v + RHALF) >>> SH;
      if (r > QHI) begin
         r = QHI;
      end else if (r < QLO) begin
         r = QLO;
      end
      return r[QW-1:0];
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   eqc_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock (clock), .en (adv), .angle (req_pitch_deg), .sc (pit)
   );
   eqc_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock (clock), .en (adv), .angle (req_yaw_deg), .sc (yaw)
   );
   eqc_angle #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock (clock), .en (adv), .angle (req_roll_deg), .sc (rol)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   // Datapath: products, rounding, yaw products, sums, output rounding and saturation.
   always_ff @(posedge clock) begin
      if (adv) begin
         m_crsp_ff <= rol.c * pit.s;
         m_srcp_ff <= rol.s * pit.c;
         m_crcp_ff <= rol.c * pit.c;
         m_srsp_ff <= rol.s * pit.s;
         yaw1_ff   <= yaw;

         r_crsp_ff <= rnd30(m_crsp_ff);
         r_srcp_ff <= rnd30(m_srcp_ff);
         r_crcp_ff <= rnd30(m_crcp_ff);
         r_srsp_ff <= rnd30(m_srsp_ff);
         yaw2_ff   <= yaw1_ff;

         t_ff[0] <= r_crsp_ff * yaw2_ff.s;
         t_ff[1] <= r_srcp_ff * yaw2_ff.c;
         t_ff[2] <= r_crsp_ff * yaw2_ff.c;
         t_ff[3] <= r_srcp_ff * yaw2_ff.s;
         t_ff[4] <= r_crcp_ff * yaw2_ff.s;
         t_ff[5] <= r_srsp_ff * yaw2_ff.c;
         t_ff[6] <= r_crcp_ff * yaw2_ff.c;
         t_ff[7] <= r_srsp_ff * yaw2_ff.s;

         qx_ff <= SW'(t_ff[0]) - SW'(t_ff[1]);
         qy_ff <= -SW'(t_ff[2]) - SW'(t_ff[3]);
         qz_ff <= SW'(t_ff[4]) - SW'(t_ff[5]);
         qw_ff <= SW'(t_ff[6]) + SW'(t_ff[7]);

         ox_ff <= to_out(qx_ff);
         oy_ff <= to_out(qy_ff);
         oz_ff <= to_out(qz_ff);
         ow_ff <= to_out(qw_ff);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_x = ox_ff;
   assign rsp_quat_y = oy_ff;
   assign rsp_quat_z = oz_ff;
   assign rsp_quat_w = ow_ff;

   // A held result must stall the input side.
   `EQC_ASSERT_NOW(a_stall_blocks_input, clock, rsp_valid && !rsp_ready, !req_ready)
   // Nothing comes out straight after reset.
   `EQC_ASSERT_NOW(a_reset_clears_out, clock, !reset && $past(reset), !rsp_valid)
   // An accepted item enters the first valid stage.
   `EQC_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[0])
   // A stalled pipe keeps its occupancy.
   `EQC_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(valid_ff))

endmodule

[tb/sv/tb_euler_to_quaternion_top.sv]
// Self-checking testbench for the Euler-angle to quaternion pipeline.
module tb_euler_to_quaternion_top;

   localparam int STAGES   = 16;
   localparam int OFB      = 15;
   localparam int N_STAGES = (STAGES < 24) ? STAGES : 24;
   localparam int LATENCY  = N_STAGES + 15;

   localparam longint TURN_Q16 = 64'sd23592960;
   localparam longint HALF_90  = 64'sd9000000000000;
   localparam longint HALF_180 = 64'sd18000000000000;
   localparam longint K_GAIN   = 64'sd2608131496;
   localparam logic signed [31:0] D360 = 32'sd23592960;
   localparam logic signed [31:0] D1   = 32'sd65536;

   // arctangent of 2^-i in 1e-11 degree units
   localparam longint ARCTAN [24] = '{
      64'sd4500000000000, 64'sd2656505117708, 64'sd1403624346793, 64'sd712501634890,
      64'sd357633437500, 64'sd178991060825, 64'sd89517371021, 64'sd44761417086,
      64'sd22381050037, 64'sd11190567707, 64'sd5595289189, 64'sd2797645262,
      64'sd1398822714, 64'sd699411368, 64'sd349705685, 64'sd174852843,
      64'sd87426421, 64'sd43713211, 64'sd21856605, 64'sd10928303,
      64'sd5464151, 64'sd2732076, 64'sd1366038, 64'sd683019
   };

   typedef struct {
      logic signed [OFB:0] x;
      logic signed [OFB:0] y;
      logic signed [OFB:0] z;
      logic signed [OFB:0] w;
   } quat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_pitch_deg = '0;
   logic signed [31:0] req_yaw_deg   = '0;
   logic signed [31:0] req_roll_deg  = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OFB:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;

   euler_to_quaternion_top #(.CORDIC_STAGES(STAGES), .OUT_FRAC_BITS(OFB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pitch_deg(req_pitch_deg), .req_yaw_deg(req_yaw_deg),
      .req_roll_deg(req_roll_deg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w)
   );

   // Scoreboard state
   quat_t  expected_quats[$];
   int     mismatches = 0;
   int     items_sent = 0;
   int     quats_seen = 0;
   bit     idle_free  = 1'b0;   // when set, neither side idles

   initial begin
      forever #4 clock = ~clock;
   end

   // ---- prediction ---------------------------------------------------------

   function automatic longint fshift(longint v, int s);
      return v >>> s;   // arithmetic shift is a floor shift
   endfunction

   function automatic longint rshift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Q16.16 degrees to half angle in 1e-11 degree units, fmod-style remainder
   function automatic longint half_units(logic signed [31:0] raw);
      longint a, r, h;
      longint unsigned m;
      a = raw;
      r = a % TURN_Q16;
      m = (r < 0) ? -r : r;
      h = longint'((m * 64'd100000000000 + 64'd65536) >> 17);
      return (r < 0) ? -h : h;
   endfunction

   function automatic void cordic_sincos(input longint zin, output longint sn,
                                         output longint cs);
      longint x, y, z, nx;
      bit flip;
      x = K_GAIN; y = 0; z = zin; flip = 1'b0;
      if (z > HALF_90) begin
         z -= HALF_180; flip = 1'b1;
      end else if (z < -HALF_90) begin
         z += HALF_180; flip = 1'b1;
      end
      for (int i = 0; i < N_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - fshift(y, i); y = y + fshift(x, i); z -= ARCTAN[i];
         end else begin
            nx = x + fshift(y, i); y = y - fshift(x, i); z += ARCTAN[i];
         end
         x = nx;
      end
      x = rshift(x, 2);
      y = rshift(y, 2);
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic logic signed [OFB:0] sat_q(longint v60);
      longint v, hi, lo;
      v  = rshift(v60, 60 - OFB);
      hi = (64'sd1 <<< OFB) - 1;
      lo = -(64'sd1 <<< OFB);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OFB:0];
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return rshift(a * b, 30);
   endfunction

   function automatic quat_t predict_quat(logic signed [31:0] p, logic signed [31:0] yw,
                                          logic signed [31:0] r);
      longint sp, cp, sy, cy, sr, cr;
      quat_t q;
      cordic_sincos(half_units(p), sp, cp);
      cordic_sincos(half_units(yw), sy, cy);
      cordic_sincos(half_units(r), sr, cr);
      q.x = sat_q(mul_q30(cr, sp) * sy - mul_q30(sr, cp) * cy);
      q.y = sat_q(-(mul_q30(cr, sp) * cy) - mul_q30(sr, cp) * sy);
      q.z = sat_q(mul_q30(cr, cp) * sy - mul_q30(sr, sp) * cy);
      q.w = sat_q(mul_q30(cr, cp) * cy + mul_q30(sr, sp) * sy);
      return q;
   endfunction

   // ---- stimulus -----------------------------------------------------------

   // Send one item; idles first at random, holds valid until accepted.
   task automatic send_angles(logic signed [31:0] p, logic signed [31:0] yw,
                              logic signed [31:0] r);
      if (!idle_free) begin
         while ($urandom_range(99) < 29) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_pitch_deg <= p;
      req_yaw_deg   <= yw;
      req_roll_deg  <= r;
      expected_quats.push_back(predict_quat(p, yw, r));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Pick one angle: mostly within a few turns, sometimes anywhere in 32 bits
   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return D360 * $signed($urandom_range(8) - 4);     // whole turns
         3:       return (D1 * 180) * $signed($urandom_range(4) - 2) // half turns, nudged
                         + $signed($urandom_range(4) - 2);
         default: return $signed($urandom_range(32'd47185920)) - 32'sd23592960;
      endcase
   endfunction

   // Corners: the extremes of the fields, whole and half turns, the fold points
   task automatic test_corners();
      logic signed [31:0] c [14];
      c = '{32'sh80000000, 32'sh7fffffff, 0, 1, -1, D360, -D360, D360 - 1,
            -(D360 - 1), D1 * 180, -(D1 * 180), D1 * 90, D1 * 270, 32'shffffffff};
      for (int i = 0; i < 14; i++)
         send_angles(c[i], c[(i + 5) % 14], c[(i + 9) % 14]);
      send_angles(0, 0, 0);                                  // identity, W at +1
      send_angles(D1 * 360 * 2 - 1, -(D1 * 180 + 1), D1 * 179);
      send_angles(32'sh80000000, 32'sh80000000, 32'sh80000000);
      send_angles(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_angles(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
      go_quiet();
   endtask

   // Random angles with random idling on both sides
   task automatic test_random(int n);
      for (int i = 0; i < n; i++)
         send_angles(rand_angle(), rand_angle(), rand_angle());
      go_quiet();
   endtask

   // Back-to-back stretch with both sides always ready
   task automatic test_full_rate(int n);
      idle_free = 1'b1;
      for (int i = 0; i < n; i++)
         send_angles($urandom, rand_angle(), rand_angle());
      go_quiet();
      idle_free = 1'b0;
   endtask

   // Hold off until the pipe has drained, then resume
   task automatic test_drain_then_resume(int n);
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      test_random(n);
   endtask

   // ---- result side --------------------------------------------------------

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (idle_free)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      quat_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         quats_seen++;
         if (expected_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%0d y=%0d z=%0d w=%0d",
                        rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
         end else begin
            e = expected_quats.pop_front();
            if (rsp_quat_x !== e.x || rsp_quat_y !== e.y ||
                rsp_quat_z !== e.z || rsp_quat_w !== e.w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch #%0d: exp x=%0d y=%0d z=%0d w=%0d, got %0d %0d %0d %0d",
                           quats_seen, e.x, e.y, e.z, e.w,
                           rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
            end
         end
      end
   end

   // ---- sequence -----------------------------------------------------------

   initial begin
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random(700);
      test_drain_then_resume(300);
      test_full_rate(300);
      test_random(330);
      waited = 0;
      while (expected_quats.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d angle triples (corners, random, full rate, drained pause); %0d checked.",
               items_sent, quats_seen);
      if (mismatches == 0 && expected_quats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_quats.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   // Generous limit: far beyond the slowest correct run
   initial begin
      #4000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
